// ----- sv/fbe_pkg.sv -----
// Package for the byte-stuffed frame encoder.
// Holds the shared types, codes and constants; no dependencies.
package fbe_pkg;

  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [BYTE_W-1:0] STUFF_XOR = 8'h20;
  localparam int                SEQ_SHIFT = 6;

  localparam logic [BYTE_W-1:0] FLAG_RESET = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_RESET  = 8'h7D;
  localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h03;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FLAG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR   = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] flag;
    logic [BYTE_W-1:0] escape;
    logic [BYTE_W-1:0] address;
  } fbe_cfg_t;

  // One classified payload byte, queued for the back end
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] check;
    logic              open;
    logic              last;
    logic              seq;
  } fbe_cmd_t;

  // Line byte sequencer steps
  typedef enum logic [3:0] {
    ST_START,
    ST_FLAG,
    ST_ADDR,
    ST_CTRL,
    ST_HCS,
    ST_DATA,
    ST_DATA_X,
    ST_CHK,
    ST_CHK_X,
    ST_CLOSE
  } fbe_step_t;

endpackage

// ----- sv/fbe_front.sv -----
// Front end: accepts payload beats and classifies them into queue commands.
// Tracks frame open state, running check and sequence bit; uses fbe_pkg.
module fbe_front import fbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [BYTE_W-1:0] s_tdata,   // payload_byte
  input  logic              s_tlast,   // last_of_frame
  input  logic              q_full,
  output logic              push,
  output fbe_cmd_t          push_cmd
);

  logic              inside_frame;
  logic [BYTE_W-1:0] running_check;
  logic              sequence_bit;
  logic [BYTE_W-1:0] check_next;

  assign s_tready   = !q_full;
  assign push       = s_tvalid && s_tready;
  assign check_next = (inside_frame ? running_check : '0) ^ s_tdata;

  // Build the command for the back end
  always_comb begin
    push_cmd.data  = s_tdata;
    push_cmd.check = check_next;
    push_cmd.open  = !inside_frame;
    push_cmd.last  = s_tlast;
    push_cmd.seq   = sequence_bit;
  end

  // Advance frame state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame  <= 1'b0;
      running_check <= '0;
      sequence_bit  <= 1'b0;
    end else if (push) begin
      if (s_tlast) begin
        inside_frame  <= 1'b0;
        running_check <= '0;
        sequence_bit  <= !sequence_bit;
      end else begin
        inside_frame  <= 1'b1;
        running_check <= check_next;
      end
    end
  end

endmodule

// ----- sv/fbe_fifo.sv -----
// Short command queue between the front and back ends.
// Register-based ring of FIFO_DEPTH entries; uses fbe_pkg.
module fbe_fifo import fbe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  fbe_cmd_t push_cmd,
  input  logic     pop,
  output fbe_cmd_t head,
  output logic     not_empty,
  output logic     full
);

  fbe_cmd_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == FIFO_CW'(FIFO_DEPTH));

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/fbe_back.sv -----
// Back end: expands queued commands into line bytes, one beat per cycle unless stalled.
// Sequences header, stuffed data, stuffed check and closing flag; uses fbe_pkg.
module fbe_back import fbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  fbe_cfg_t          cfg,
  input  fbe_cmd_t          head,
  input  logic              head_valid,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [BYTE_W-1:0] m_tdata,   // line_byte
  output logic              m_tlast    // frame_end
);

  fbe_step_t         step;
  fbe_step_t         step_next;
  fbe_step_t         cur;
  logic              done;
  logic              advance;
  logic              data_stuff;
  logic              chk_stuff;
  logic [BYTE_W-1:0] ctrl;
  logic [BYTE_W-1:0] byte_out;
  logic              end_out;

  assign advance    = head_valid && (!m_tvalid || m_tready);
  assign pop        = advance && done;
  assign data_stuff = (head.data == cfg.flag) || (head.data == cfg.escape);
  assign chk_stuff  = (head.check == cfg.flag) || (head.check == cfg.escape);
  assign ctrl       = BYTE_W'(head.seq) << SEQ_SHIFT;

  // Pick the step to emit: a fresh command starts at header or data
  always_comb begin
    if (step == ST_START) begin
      cur = head.open ? ST_FLAG : ST_DATA;
    end else begin
      cur = step;
    end
  end

  // Next step and end of command
  always_comb begin
    step_next = ST_START;
    done      = 1'b0;
    case (cur)
      ST_FLAG:   step_next = ST_ADDR;
      ST_ADDR:   step_next = ST_CTRL;
      ST_CTRL:   step_next = ST_HCS;
      ST_HCS:    step_next = ST_DATA;
      ST_DATA: begin
        if (data_stuff) begin
          step_next = ST_DATA_X;
        end else if (head.last) begin
          step_next = ST_CHK;
        end else begin
          done = 1'b1;
        end
      end
      ST_DATA_X: begin
        if (head.last) begin
          step_next = ST_CHK;
        end else begin
          done = 1'b1;
        end
      end
      ST_CHK:    step_next = chk_stuff ? ST_CHK_X : ST_CLOSE;
      ST_CHK_X:  step_next = ST_CLOSE;
      ST_CLOSE:  done = 1'b1;
      default:   done = 1'b1;
    endcase
  end

  // Line byte for the current step
  always_comb begin
    byte_out = cfg.flag;
    end_out  = 1'b0;
    case (cur)
      ST_FLAG:   byte_out = cfg.flag;
      ST_ADDR:   byte_out = cfg.address;
      ST_CTRL:   byte_out = ctrl;
      ST_HCS:    byte_out = cfg.address ^ ctrl;
      ST_DATA:   byte_out = data_stuff ? cfg.escape : head.data;
      ST_DATA_X: byte_out = head.data ^ STUFF_XOR;
      ST_CHK:    byte_out = chk_stuff ? cfg.escape : head.check;
      ST_CHK_X:  byte_out = head.check ^ STUFF_XOR;
      ST_CLOSE: begin
        byte_out = cfg.flag;
        end_out  = 1'b1;
      end
      default:   byte_out = cfg.flag;
    endcase
  end

  // Sequencer state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= ST_START;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      step     <= done ? ST_START : step_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= byte_out;
      m_tlast <= end_out;
    end
  end

endmodule

// ----- sv/byte_stuffed_frame_encoder.sv -----
// Byte-stuffed frame encoder: accepted payload beats pass through the command
// queue to the output register. Each command becomes line bytes (header before an
// opening byte, escape pair if stuffed, check and flag after the last), one byte
// per cycle unless stalled; a 4-entry queue lets input beats arrive back to back.
// Synchronous active-high reset clears frame state, queue and output valid, and
// restores flag 0x7E, escape 0x7D and address 0x03.
module byte_stuffed_frame_encoder import fbe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,    // [7:0] payload_byte
  input  logic                 s_tlast,    // last_of_frame
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [BYTE_W-1:0]    m_tdata,    // [7:0] line_byte
  output logic                 m_tlast,    // frame_end
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  fbe_cfg_t cfg;
  fbe_cmd_t push_cmd;
  fbe_cmd_t head;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_not_empty;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag    <= FLAG_RESET;
      cfg.escape  <= ESC_RESET;
      cfg.address <= ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FLAG:   cfg.flag    <= cfg_data;
        REG_ESCAPE: cfg.escape  <= cfg_data;
        REG_ADDR:   cfg.address <= cfg_data;
        default: ;
      endcase
    end
  end

  fbe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  fbe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  fbe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (q_not_empty),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

// ----- sv/fbe_checker.sv -----
// Port-level checker for the byte-stuffed frame encoder, bound to the top level.
// Uses fbe_pkg for widths.
module fbe_checker import fbe_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [BYTE_W-1:0] m_tdata,
  input logic              m_tlast
);

  logic prev_last;

  // Remember whether the last delivered beat closed a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_last <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      prev_last <= m_tlast;
    end
  end

  // Output empties on reset
  a_out_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Queue is empty after reset, so input is ready
  a_in_ready_reset: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output beat changed");

  // Every frame has header bytes, so two closing flags never follow one another
  a_no_double_close: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |-> !prev_last)
    else $error("two frame ends in a row");

endmodule

bind byte_stuffed_frame_encoder fbe_checker u_fbe_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast)
);
